### design/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types, constants and helper functions for the triangle span walker.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    localparam logic [2:0] REG_CLIP_X_MIN = 3'd0;
    localparam logic [2:0] REG_CLIP_X_MAX = 3'd1;
    localparam logic [2:0] REG_CLIP_Y_MIN = 3'd2;
    localparam logic [2:0] REG_CLIP_Y_MAX = 3'd3;
    localparam logic [2:0] REG_FIELD_MODE = 3'd4;
    localparam logic [2:0] REG_KEEP_ODD   = 3'd5;

    localparam logic [1:0] WORD_HEADER = 2'd0;
    localparam logic [1:0] WORD_LOWER  = 2'd1;
    localparam logic [1:0] WORD_MAJOR  = 2'd2;
    localparam logic [1:0] WORD_UPPER  = 2'd3;

    localparam int MAJOR_BIT = 55;
    localparam logic [27:0] POS_MASK = 28'hffffffe;

    // One edge sample request to the shared sampler.
    typedef struct packed {
        logic [63:0]        word;
        logic signed [15:0] rows;
    } edge_req_t;

    // Edge X at a quarter-row offset, eighth pixels with sticky bit, 15-bit signed.
    function automatic logic signed [14:0] edge_at(input logic [63:0] w,
                                                   input logic signed [15:0] rows);
        logic [27:0] pos;
        logic [27:0] stp;
        logic [27:0] val;
        logic [27:0] rs;
        pos = w[59:32] & POS_MASK;
        stp = w[29:2] & POS_MASK;
        rs  = {{12{rows[15]}}, rows};
        val = pos + 28'(stp * rs);
        return {val[27:14], val[13] | (val[12:0] != 13'd0)};
    endfunction

    function automatic logic signed [15:0] half_floor(input logic signed [15:0] v);
        return v >>> 1;
    endfunction

endpackage

### design/triangle_span_walker.sv
// ----------------------------------------------------------------------------
// triangle_span_walker
// Edge-walking span generator for fill and copy triangles.
// ----------------------------------------------------------------------------
// A load gives no result and leaves busy low. After a walk step is accepted,
// busy stays high while four quarter-row samples pass through the shared
// edge sampler, the last sample is folded and the result is registered. The
// result strobe comes once busy has fallen, when the next item can already be
// accepted. An empty triangle or a finished walk goes straight to the done
// state. One result per step, never stalled. Reset clears the walk state.
module triangle_span_walker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [1:0]  word_index,
    input  logic [63:0] command_word,
    input  logic        copy_mode,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        result_valid,
    output logic        span_valid,
    output logic [9:0]  scan_row,
    output logic [9:0]  start_x,
    output logic [9:0]  end_x,
    output logic        copy_span,
    output logic        last_line
);
    import tsw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SAMP = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [63:0] store_reg [4];
    logic [11:0] clip_x_min_reg, clip_x_max_reg, clip_y_min_reg, clip_y_max_reg;
    logic        field_mode_reg, keep_odd_reg;
    logic [11:0] line_reg;
    logic        active_reg;
    logic [2:0]  state_reg;
    logic [2:0]  sub_reg;          // number of samples issued
    logic        samp_vld_reg;     // sampler output holds a sample
    logic [1:0]  samp_sub_reg;
    logic        copy_reg, last_reg, skip_reg, early_reg;
    logic [9:0]  row_reg;
    logic        ol_reg, or_reg, any_reg;
    logic signed [16:0] left_reg, right_reg;
    logic        res_vld_reg, res_span_reg;
    logic [9:0]  res_x0_reg, res_x1_reg, res_row_reg;
    logic        res_copy_reg, res_last_reg;

    // Header decode.
    logic               major_on_left;
    logic signed [15:0] top, middle, bottom, origin, first, limit, last_row;
    logic signed [15:0] cl, cr;
    logic               empty;

    assign major_on_left = store_reg[WORD_HEADER][MAJOR_BIT];
    assign top    = 16'(signed'(store_reg[WORD_HEADER][13:0]));
    assign middle = 16'(signed'(store_reg[WORD_HEADER][29:16]));
    assign bottom = 16'(signed'(store_reg[WORD_HEADER][45:32]));
    assign origin = top - 16'(top[1:0]);
    assign first  = (top > signed'({4'd0, clip_y_min_reg})) ? top
                  : signed'({4'd0, clip_y_min_reg});
    assign limit  = (bottom < signed'({4'd0, clip_y_max_reg})) ? bottom
                  : signed'({4'd0, clip_y_max_reg});
    assign cl = signed'({3'd0, clip_x_min_reg, 1'b0});
    assign cr = signed'({3'd0, clip_x_max_reg, 1'b0});
    assign empty = (first >= limit) || (cl > cr);
    assign last_row = (limit - 16'sd1) >>> 2;

    // Sample issue.
    edge_req_t          req_a, req_b;
    logic signed [15:0] row_issue;
    logic signed [14:0] xa, xb;
    logic signed [15:0] row_samp;

    assign row_issue = signed'({2'b0, row_reg, sub_reg[1:0]});
    always_comb
    begin
        req_a.word = store_reg[WORD_MAJOR];
        req_a.rows = row_issue - origin;
        if (middle >= origin && row_issue >= middle)
        begin
            req_b.word = store_reg[WORD_LOWER];
            req_b.rows = row_issue - middle;
        end
        else
        begin
            req_b.word = store_reg[WORD_UPPER];
            req_b.rows = row_issue - origin;
        end
    end

    tsw_sampler u_sampler
    (
        .clk   (clk),
        .req_a (req_a),
        .req_b (req_b),
        .xa    (xa),
        .xb    (xb)
    );

    // Fold one sample into the span.
    logic signed [16:0] l, r, lc, rc, mx, mn;
    logic               cov;
    assign row_samp = signed'({2'b0, row_reg, samp_sub_reg});
    assign l  = major_on_left ? 17'(xa) : 17'(xb);
    assign r  = major_on_left ? 17'(xb) : 17'(xa);
    assign mx = (l > r) ? l : r;
    assign mn = (l < r) ? l : r;
    assign lc = (l < 17'(cl)) ? 17'(cl) : ((l > 17'(cr)) ? 17'(cr) : l);
    assign rc = (r < 17'(cl)) ? 17'(cl) : ((r > 17'(cr)) ? 17'(cr) : r);
    assign cov = !(row_samp < first || row_samp >= limit
                   || half_floor(16'(l)) > half_floor(16'(r)));

    logic signed [16:0] y_start;
    assign y_start = 17'(first >>> 2);

    assign busy = (state_reg != ST_IDLE);
    // A register write never lands in the same cycle as an item transfer.
    assign cfg_ready = (state_reg == ST_IDLE) && !start;

    always_ff @(posedge clk)
    begin
        if (start && !busy && op == OP_LOAD)
            store_reg[word_index] <= command_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_min_reg <= 12'd0;
            clip_x_max_reg <= 12'd4095;
            clip_y_min_reg <= 12'd0;
            clip_y_max_reg <= 12'd4095;
            field_mode_reg <= 1'b0;
            keep_odd_reg   <= 1'b0;
            line_reg       <= 12'd0;
            active_reg     <= 1'b0;
            state_reg      <= ST_IDLE;
            sub_reg        <= 3'd0;
            samp_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            res_vld_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CLIP_X_MIN: clip_x_min_reg <= cfg_data;
                    REG_CLIP_X_MAX: clip_x_max_reg <= cfg_data;
                    REG_CLIP_Y_MIN: clip_y_min_reg <= cfg_data;
                    REG_CLIP_Y_MAX: clip_y_max_reg <= cfg_data;
                    REG_FIELD_MODE: field_mode_reg <= cfg_data[0];
                    REG_KEEP_ODD:   keep_odd_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && op == OP_LOAD)
                        active_reg <= 1'b0;
                    else if (start)
                    begin
                        copy_reg  <= copy_mode;
                        ol_reg    <= 1'b1;
                        or_reg    <= 1'b1;
                        any_reg   <= 1'b0;
                        left_reg  <= 17'sh0ffff;
                        right_reg <= 17'sd0;
                        sub_reg   <= 3'd0;
                        samp_vld_reg <= 1'b0;
                        state_reg <= ST_DONE;
                        early_reg <= 1'b1;
                        skip_reg  <= 1'b1;
                        last_reg  <= 1'b1;
                        row_reg   <= 10'd0;
                        if (!active_reg && !empty)
                        begin
                            early_reg <= 1'b0;
                            row_reg   <= 10'(first >>> 2);
                            if (y_start >= 17'(last_row))
                                active_reg <= 1'b0;
                            else
                            begin
                                active_reg <= 1'b1;
                                line_reg <= 12'(y_start + 17'sd1);
                                last_reg <= 1'b0;
                            end
                            skip_reg <= field_mode_reg && (y_start[0] != keep_odd_reg);
                            state_reg <= ST_SAMP;
                        end
                        else if (active_reg && !(empty
                                 || signed'({5'd0, line_reg}) > 17'(last_row)))
                        begin
                            early_reg <= 1'b0;
                            row_reg   <= line_reg[9:0];
                            if (signed'({5'd0, line_reg}) >= 17'(last_row))
                                active_reg <= 1'b0;
                            else
                            begin
                                line_reg <= line_reg + 12'd1;
                                last_reg <= 1'b0;
                            end
                            skip_reg <= field_mode_reg && (line_reg[0] != keep_odd_reg);
                            state_reg <= ST_SAMP;
                        end
                        else
                            active_reg <= 1'b0;
                    end
                end
                ST_SAMP, ST_FOLD:
                begin
                    samp_sub_reg <= sub_reg[1:0];
                    samp_vld_reg <= (state_reg == ST_SAMP);
                    if (state_reg == ST_SAMP)
                    begin
                        sub_reg <= sub_reg + 3'd1;
                        if (sub_reg == 3'd3)
                            state_reg <= ST_FOLD;
                    end
                    else
                        state_reg <= ST_DONE;
                    if (samp_vld_reg)
                    begin
                        ol_reg <= ol_reg && (mx < 17'(cl));
                        or_reg <= or_reg && (mn >= 17'(cr));
                        if (cov)
                        begin
                            any_reg <= 1'b1;
                            if (lc < left_reg)
                                left_reg <= lc;
                            if (rc > right_reg)
                                right_reg <= rc;
                        end
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                    res_vld_reg <= 1'b1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic span_ok;
    assign span_ok = !early_reg && !skip_reg && any_reg && !ol_reg && !or_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            res_span_reg <= span_ok;
            res_row_reg  <= early_reg ? 10'd0 : row_reg;
            res_x0_reg   <= span_ok ? left_reg[12:3] : 10'd0;
            res_x1_reg   <= span_ok ? right_reg[12:3] : 10'd0;
            res_copy_reg <= copy_reg;
            res_last_reg <= last_reg;
        end
    end

    assign result_valid = res_vld_reg;
    assign span_valid   = res_span_reg;
    assign scan_row     = res_row_reg;
    assign start_x      = res_x0_reg;
    assign end_x        = res_x1_reg;
    assign copy_span    = res_copy_reg;
    assign last_line    = res_last_reg;
endmodule

### design/tsw_sampler.sv
// ----------------------------------------------------------------------------
// tsw_sampler
// Shared edge sampler: both edges of a request pair evaluated, result registered.
// ----------------------------------------------------------------------------
module tsw_sampler
(
    input  logic                       clk,
    input  tsw_pkg::edge_req_t         req_a,
    input  tsw_pkg::edge_req_t         req_b,
    output logic signed [14:0]         xa,
    output logic signed [14:0]         xb
);
    import tsw_pkg::*;

    logic signed [14:0] xa_reg;
    logic signed [14:0] xb_reg;

    always_ff @(posedge clk)
    begin
        xa_reg <= edge_at(req_a.word, req_a.rows);
        xb_reg <= edge_at(req_b.word, req_b.rows);
    end

    assign xa = xa_reg;
    assign xb = xb_reg;
endmodule

### tb/triangle_span_walker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_span_walker_tb
// Self-checking testbench for the triangle span walker. Triangle command words
// are loaded and scanlines are walked with random gaps between transfers. The
// scissor and field registers are reprogrammed between phases. A local model
// of the edge walker predicts every span, and each result strobe is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_span_walker_tb;
    import tsw_pkg::*;

    typedef struct packed {
        logic       span_valid;
        logic [9:0] scan_row;
        logic [9:0] start_x;
        logic [9:0] end_x;
        logic       copy_span;
        logic       last_line;
    } span_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [1:0]  word_index;
    logic [63:0] command_word;
    logic        copy_mode;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        result_valid;
    logic        span_valid;
    logic [9:0]  scan_row;
    logic [9:0]  start_x;
    logic [9:0]  end_x;
    logic        copy_span;
    logic        last_line;

    triangle_span_walker dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .word_index   (word_index),
        .command_word (command_word),
        .copy_mode    (copy_mode),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .span_valid   (span_valid),
        .scan_row     (scan_row),
        .start_x      (start_x),
        .end_x        (end_x),
        .copy_span    (copy_span),
        .last_line    (last_line)
    );

    // Model state of the walker.
    logic [63:0] tri_words [4];
    int          line_now;
    bit          walking;
    int          x_min, x_max, y_min, y_max;
    bit          field_on, keep_odd;

    span_t       pending_spans [$];
    int          item_count;
    int          cfg_count;
    int          fail_count;
    int          items_sent;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int sample_edge(logic [63:0] w, int rows);
        logic [31:0] pos;
        logic [31:0] stp;
        logic [31:0] val;
        logic [14:0] u;
        pos = w[63:32] & 32'h0ffffffe;
        stp = (w[31:0] >> 2) & 32'h0ffffffe;
        val = pos + stp * rows;
        u = val[27:13];
        u[0] = u[0] | (val[12:0] != 13'd0);
        return int'($signed(u));
    endfunction

    function automatic int min_i(int a, int b);
        return a < b ? a : b;
    endfunction

    function automatic int max_i(int a, int b);
        return a > b ? a : b;
    endfunction

    function automatic span_t walk_line(logic cp);
        span_t res;
        bit    major_left, empty, out_l, out_r, covered;
        int    top, middle, bottom, origin, first, limit, cl, cr, last_row, y, row;
        int    xmaj, xmin, l, r, left, right;
        out_l = 1; out_r = 1; covered = 0; left = 'hffff; right = 0;
        major_left = tri_words[WORD_HEADER][MAJOR_BIT];
        top    = int'($signed(tri_words[WORD_HEADER][13:0]));
        middle = int'($signed(tri_words[WORD_HEADER][29:16]));
        bottom = int'($signed(tri_words[WORD_HEADER][45:32]));
        origin = top - ((top + 8192) & 3);
        first  = max_i(top, y_min);
        limit  = min_i(bottom, y_max);
        cl = x_min * 2;
        cr = x_max * 2;
        empty = first >= limit || cl > cr;
        last_row = empty ? 0 : (limit - 1) >>> 2;
        res = '0;
        res.copy_span = cp;
        res.last_line = 1'b1;
        if (!walking)
        begin
            if (empty)
                return res;
            line_now = first >>> 2;
            walking = 1;
        end
        else if (empty || line_now > last_row)
        begin
            walking = 0;
            return res;
        end
        y = line_now;
        if (y >= last_row)
            walking = 0;
        else
        begin
            line_now = (y + 1) & 'hfff;
            res.last_line = 1'b0;
        end
        res.scan_row = y[9:0];
        if (field_on && (y & 1) != int'(keep_odd))
            return res;
        for (int sub = 0; sub < 4; sub++)
        begin
            row = y * 4 + sub;
            xmaj = sample_edge(tri_words[WORD_MAJOR], row - origin);
            if (middle >= origin && row >= middle)
                xmin = sample_edge(tri_words[WORD_LOWER], row - middle);
            else
                xmin = sample_edge(tri_words[WORD_UPPER], row - origin);
            l = major_left ? xmaj : xmin;
            r = major_left ? xmin : xmaj;
            out_l = out_l && max_i(l, r) < cl;
            out_r = out_r && min_i(l, r) >= cr;
            if (row < first || row >= limit || (l >>> 1) > (r >>> 1))
                continue;
            covered = 1;
            left  = min_i(left, max_i(cl, min_i(l, cr)));
            right = max_i(right, max_i(cl, min_i(r, cr)));
        end
        if (covered && !out_l && !out_r)
        begin
            res.span_valid = 1'b1;
            res.start_x = 10'((left >>> 3) & 'h3ff);
            res.end_x   = 10'((right >>> 3) & 'h3ff);
        end
        return res;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Tracks every transfer at the clock edge and checks each result strobe.
    always @(posedge clk)
    begin
        span_t exp_s;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CLIP_X_MIN: x_min = cfg_data;
                    REG_CLIP_X_MAX: x_max = cfg_data;
                    REG_CLIP_Y_MIN: y_min = cfg_data;
                    REG_CLIP_Y_MAX: y_max = cfg_data;
                    REG_FIELD_MODE: field_on = cfg_data[0];
                    REG_KEEP_ODD:   keep_odd = cfg_data[0];
                    default: ;
                endcase
                cfg_count++;
            end
            if (result_valid)
            begin
                if (pending_spans.size() == 0)
                begin
                    $error("unexpected result at row %0d", scan_row);
                    fail_count++;
                end
                else
                begin
                    exp_s = pending_spans.pop_front();
                    check_field("span_valid", exp_s.span_valid, span_valid);
                    check_field("scan_row", exp_s.scan_row, scan_row);
                    check_field("start_x", exp_s.start_x, start_x);
                    check_field("end_x", exp_s.end_x, end_x);
                    check_field("copy_span", exp_s.copy_span, copy_span);
                    check_field("last_line", exp_s.last_line, last_line);
                end
            end
            if (start && !busy)
            begin
                if (op == OP_LOAD)
                begin
                    tri_words[word_index] = command_word;
                    walking = 0;
                end
                else
                    pending_spans.push_back(walk_line(copy_mode));
                item_count++;
            end
        end
    end

    task automatic send_item(logic o, logic [1:0] idx, logic [63:0] w, logic cp);
        int gap;
        int seen;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        seen = item_count;
        start        <= 1'b1;
        op           <= o;
        word_index   <= idx;
        command_word <= w;
        copy_mode    <= cp;
        do @(negedge clk); while (item_count == seen);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        int seen;
        start <= 1'b0;
        @(negedge clk);
        wait (pending_spans.size() == 0);
        repeat (8) @(negedge clk);
        seen = cfg_count;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (cfg_count == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_scissor(int xl, int xr, int yt, int yb, bit fm, bit odd);
        write_reg(REG_CLIP_X_MIN, 12'(xl));
        write_reg(REG_CLIP_X_MAX, 12'(xr));
        write_reg(REG_CLIP_Y_MIN, 12'(yt));
        write_reg(REG_CLIP_Y_MAX, 12'(yb));
        write_reg(REG_FIELD_MODE, 12'(fm));
        write_reg(REG_KEEP_ODD, 12'(odd));
    endtask

    function automatic logic [63:0] make_header(int top, int mid, int bot, bit major);
        logic [63:0] h;
        h = {$urandom, $urandom};
        h[13:0]  = 14'(top);
        h[29:16] = 14'(mid);
        h[45:32] = 14'(bot);
        h[MAJOR_BIT] = major;
        return h;
    endfunction

    // Random edge, usually with an on-screen start and a gentle slope.
    function automatic logic [63:0] make_edge();
        logic [63:0] w;
        int          slope;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
        begin
            w[59:58] = 2'b00;
            slope = $urandom_range(0, 1 << 19) - (1 << 18);
            w[29:3] = 27'(slope);
        end
        return w;
    endfunction

    task automatic load_triangle(logic [63:0] hdr, bit cp);
        send_item(OP_LOAD, WORD_HEADER, hdr, cp);
        send_item(OP_LOAD, WORD_LOWER, make_edge(), cp);
        send_item(OP_LOAD, WORD_MAJOR, make_edge(), cp);
        send_item(OP_LOAD, WORD_UPPER, make_edge(), cp);
    endtask

    task automatic walk_lines(int n, bit cp);
        repeat (n) send_item(OP_WALK, WORD_HEADER, {$urandom, $urandom}, cp);
    endtask

    task automatic test_basic_walk();
        load_triangle(make_header(8, 20, 40, 1), 1'b1);
        walk_lines(10, 1'b1);
    endtask

    task automatic test_empty_triangle();
        send_item(OP_LOAD, WORD_HEADER, make_header(30, 30, 30, 0), 1'b0);
        walk_lines(1, 1'b0);
        send_item(OP_LOAD, WORD_LOWER, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_item(OP_LOAD, WORD_MAJOR, 64'h0, 1'b0);
        send_item(OP_LOAD, WORD_HEADER, make_header(-20, 4, 12, 0), 1'b0);
        set_scissor(4095, 0, 0, 4095, 0, 0);
        walk_lines(2, 1'b0);
    endtask

    task automatic test_field_skip();
        set_scissor(0, 4095, 0, 4095, 1, 1);
        load_triangle(make_header(0, 10, 24, 1), 1'b0);
        walk_lines(4, 1'b1);
        set_scissor(16, 2000, 5, 21, 1, 0);
        walk_lines(4, 1'b0);
    endtask

    task automatic test_abort_walk();
        set_scissor(0, 4095, 0, 4095, 0, 0);
        load_triangle(make_header(-8191, 0, 8191, 0), 1'b1);
        walk_lines(2, 1'b1);
        send_item(OP_LOAD, WORD_HEADER, make_header(4, 40, 16, 1), 1'b0);
        walk_lines(2, 1'b0);
    endtask

    task automatic test_random();
        int pick;
        int top;
        bit cp;
        while (items_sent < 900)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                pick = $urandom_range(0, 2);
                set_scissor(pick == 0 ? 0 : (pick == 1 ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 400)),
                            pick == 0 ? 4095 : $urandom_range(0, 4095),
                            pick == 0 ? 0 : $urandom_range(0, 120),
                            pick == 0 ? 4095 : $urandom_range(0, 200),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            end
            cp = $urandom_range(0, 1);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                top = $urandom_range(0, 140) - 20;
                load_triangle(make_header(top, top + $urandom_range(0, 30),
                                          top + $urandom_range(0, 50),
                                          $urandom_range(0, 1)), cp);
                walk_lines($urandom_range(1, 16), cp);
            end
            else if (pick == 7)
                send_item(OP_LOAD, 2'($urandom_range(0, 3)), {$urandom, $urandom}, cp);
            else if (pick == 8)
            begin
                send_item(OP_LOAD, WORD_HEADER,
                          make_header($urandom_range(0, 16383), $urandom_range(0, 16383),
                                      $urandom_range(0, 16383), $urandom_range(0, 1)), cp);
                walk_lines($urandom_range(1, 3), cp);
            end
            else
                walk_lines($urandom_range(1, 4), cp);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD;
        word_index = WORD_HEADER;
        command_word = '0;
        copy_mode = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CLIP_X_MIN;
        cfg_data = '0;
        item_count = 0;
        cfg_count = 0;
        fail_count = 0;
        items_sent = 0;
        line_now = 0;
        walking = 0;
        x_min = 0; x_max = 4095; y_min = 0; y_max = 4095;
        field_on = 0; keep_odd = 0;
        foreach (tri_words[i]) tri_words[i] = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_walk();
        test_empty_triangle();
        test_field_skip();
        test_abort_walk();
        test_random();

        start <= 1'b0;
        wait (pending_spans.size() == 0);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
design/tsw_pkg.sv
design/tsw_sampler.sv
design/triangle_span_walker.sv
tb/triangle_span_walker_tb.sv
